// ----- design/spcd_pkg.sv -----
// shared types for the shape pair collision pipeline
// no dependencies; imported by every module of the block but the checker
package spcd_pkg;

    typedef enum logic [1:0] {
        KIND_CC   = 2'd0,
        KIND_BB   = 2'd1,
        KIND_CB   = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

endpackage

// ----- design/spcd_front.sv -----
// front end: deltas, box interval tests, circle-box clamp, squares and overlap flag
// four register stages; depends on spcd_pkg
module spcd_front #(
    parameter int CB = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  spcd_pkg::t_kind      i_kind,
    input  logic signed [CB-1:0] i_ax,
    input  logic signed [CB-1:0] i_ay,
    input  logic signed [CB-1:0] i_bx,
    input  logic signed [CB-1:0] i_by,
    input  logic [CB-3:0]        i_eax,
    input  logic [CB-3:0]        i_eay,
    input  logic [CB-3:0]        i_ebx,
    input  logic [CB-3:0]        i_eby,
    output logic                 o_valid,
    output spcd_pkg::t_kind      o_kind,
    output logic [2*CB:0]        o_s,
    output logic                 o_hit,
    output logic                 o_sx,
    output logic                 o_sy,
    output logic [CB-1:0]        o_mdx,
    output logic [CB-1:0]        o_mdy,
    output logic [CB-2:0]        o_rs,
    output logic signed [CB+1:0] o_boxpen
);
    import spcd_pkg::*;

    localparam int W1 = CB + 1;

    // stage 1
    logic signed [W1-1:0] ax1, ay1, bx1, by1, eax1, eay1, ebx1, eby1;
    logic signed [W1-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [W1-1:0] n1_dx, n1_dy, n1_ex, n1_ey;
    logic                 n1_bhit;
    t_kind                r1_kind;
    logic signed [W1-1:0] r1_dx, r1_dy, r1_ex, r1_ey;
    logic [CB-2:0]        r1_rsx, r1_rsy;
    logic [CB-3:0]        r1_eax;
    logic                 r1_bhit, r1_vld;

    assign ax1  = W1'(i_ax);
    assign ay1  = W1'(i_ay);
    assign bx1  = W1'(i_bx);
    assign by1  = W1'(i_by);
    assign eax1 = W1'(i_eax);
    assign eay1 = W1'(i_eay);
    assign ebx1 = W1'(i_ebx);
    assign eby1 = W1'(i_eby);
    assign lo_x = bx1 - ebx1;
    assign hi_x = bx1 + ebx1;
    assign lo_y = by1 - eby1;
    assign hi_y = by1 + eby1;

    always_comb begin
        n1_dx = bx1 - ax1;
        n1_dy = by1 - ay1;
        // offset of the circle centre from its clamp point on the box
        if (ax1 < lo_x) begin
            n1_ex = ax1 - lo_x;
        end else if (ax1 > hi_x) begin
            n1_ex = ax1 - hi_x;
        end else begin
            n1_ex = '0;
        end
        if (ay1 < lo_y) begin
            n1_ey = ay1 - lo_y;
        end else if (ay1 > hi_y) begin
            n1_ey = ay1 - hi_y;
        end else begin
            n1_ey = '0;
        end
        n1_bhit = (ax1 - eax1 < bx1 + ebx1) && (ax1 + eax1 > bx1 - ebx1) &&
                  (ay1 - eay1 < by1 + eby1) && (ay1 + eay1 > by1 - eby1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_kind;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r1_ex   <= n1_ex;
            r1_ey   <= n1_ey;
            r1_rsx  <= (CB-1)'(i_eax) + (CB-1)'(i_ebx);
            r1_rsy  <= (CB-1)'(i_eay) + (CB-1)'(i_eby);
            r1_eax  <= i_eax;
            r1_bhit <= n1_bhit;
        end
    end

    // stage 2: magnitudes, multiplier operand select, per-axis box overlap
    logic [CB-1:0]        n2_mdx, n2_mdy, n2_mex, n2_mey;
    t_kind                r2_kind;
    logic                 r2_sx, r2_sy, r2_bhit, r2_vld;
    logic [CB-1:0]        r2_mdx, r2_mdy, r2_px, r2_py;
    logic [CB-2:0]        r2_thr, r2_rs;
    logic signed [CB+1:0] r2_ox, r2_oy;

    assign n2_mdx = CB'(r1_dx[CB] ? -r1_dx : r1_dx);
    assign n2_mdy = CB'(r1_dy[CB] ? -r1_dy : r1_dy);
    assign n2_mex = CB'(r1_ex[CB] ? -r1_ex : r1_ex);
    assign n2_mey = CB'(r1_ey[CB] ? -r1_ey : r1_ey);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_kind <= r1_kind;
            r2_sx   <= r1_dx[CB];
            r2_sy   <= r1_dy[CB];
            r2_mdx  <= n2_mdx;
            r2_mdy  <= n2_mdy;
            r2_px   <= (r1_kind == KIND_CB) ? n2_mex : n2_mdx;
            r2_py   <= (r1_kind == KIND_CB) ? n2_mey : n2_mdy;
            r2_thr  <= (r1_kind == KIND_CB) ? (CB-1)'(r1_eax) : r1_rsx;
            r2_rs   <= r1_rsx;
            r2_ox   <= signed'((CB+2)'(r1_rsx)) - signed'((CB+2)'(n2_mdx));
            r2_oy   <= signed'((CB+2)'(r1_rsy)) - signed'((CB+2)'(n2_mdy));
            r2_bhit <= r1_bhit;
        end
    end

    // stage 3: squares and the smaller per-axis box overlap
    t_kind                r3_kind;
    logic                 r3_sx, r3_sy, r3_bhit, r3_vld;
    logic [CB-1:0]        r3_mdx, r3_mdy;
    logic [2*CB-1:0]      r3_px2, r3_py2;
    logic [2*CB-3:0]      r3_thr2;
    logic [CB-2:0]        r3_rs;
    logic signed [CB+1:0] r3_boxpen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_kind   <= r2_kind;
            r3_sx     <= r2_sx;
            r3_sy     <= r2_sy;
            r3_mdx    <= r2_mdx;
            r3_mdy    <= r2_mdy;
            r3_px2    <= r2_px * r2_px;
            r3_py2    <= r2_py * r2_py;
            r3_thr2   <= r2_thr * r2_thr;
            r3_rs     <= r2_rs;
            r3_boxpen <= (r2_ox < r2_oy) ? r2_ox : r2_oy;
            r3_bhit   <= r2_bhit;
        end
    end

    // stage 4: sum of squares and overlap flag
    logic [2*CB:0] n4_s;
    logic          n4_hit;

    always_comb begin
        n4_s = (2*CB+1)'(r3_px2) + (2*CB+1)'(r3_py2);
        case (r3_kind)
            KIND_CC: n4_hit = n4_s < (2*CB+1)'(r3_thr2);
            KIND_BB: n4_hit = r3_bhit;
            KIND_CB: n4_hit = n4_s < (2*CB+1)'(r3_thr2);
            default: n4_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_kind   <= r3_kind;
            o_s      <= n4_s;
            o_hit    <= n4_hit;
            o_sx     <= r3_sx;
            o_sy     <= r3_sy;
            o_mdx    <= r3_mdx;
            o_mdy    <= r3_mdy;
            o_rs     <= r3_rs;
            o_boxpen <= r3_boxpen;
        end
    end

endmodule

// ----- design/spcd_sqrt.sv -----
// pipelined rounded square root, one root bit per stage plus a rounding stage
// carries a side tag along with each beat; depends on spcd_pkg
module spcd_sqrt #(
    parameter int S_W   = 49,
    parameter int TAG_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [S_W-1:0]           i_s,
    input  logic [TAG_W-1:0]         i_tag,
    output logic                     o_valid,
    output logic [(S_W+3)/2-1:0]     o_len,
    output logic [TAG_W-1:0]         o_tag
);
    import spcd_pkg::*;

    localparam int K = (S_W + 3) / 2;

    logic [2*K-1:0]   r_n    [K];
    logic [K+1:0]     r_rem  [K];
    logic [K-1:0]     r_root [K];
    logic [TAG_W-1:0] r_tag  [K];
    logic             r_vld  [K];
    logic [K:0]       rnd;

    for (genvar j = 0; j < K; j++) begin : g_step
        logic [2*K-1:0]   n_in;
        logic [K+1:0]     rem_in, rem_t, trial;
        logic [K-1:0]     root_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in, ge;

        if (j == 0) begin : g_first
            assign n_in    = (2*K)'({i_s, 2'b00});
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = i_tag;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign n_in    = r_n[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign tag_in  = r_tag[j-1];
            assign vld_in  = r_vld[j-1];
        end

        // bring down the next radicand pair and try root*4+1
        assign rem_t = {rem_in[K-1:0], n_in[2*K-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = rem_t >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j]    <= n_in << 2;
                r_rem[j]  <= ge ? rem_t - trial : rem_t;
                r_root[j] <= {root_in[K-2:0], ge};
                r_tag[j]  <= tag_in;
            end
        end
    end

    // root of 4s halved with rounding gives round-to-nearest of sqrt(s)
    assign rnd = (K+1)'(r_root[K-1]) + (K+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[K-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len <= rnd[K:1];
            o_tag <= r_tag[K-1];
        end
    end

endmodule

// ----- design/spcd_div.sv -----
// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
// carries a side tag along with each beat; depends on spcd_pkg
module spcd_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 27,
    parameter int Q_W   = 16,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num_x,
    input  logic [NUM_W-1:0] i_num_y,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_q_x,
    output logic [Q_W-1:0]   o_q_y,
    output logic [TAG_W-1:0] o_tag
);
    import spcd_pkg::*;

    localparam int W = DEN_W + Q_W;

    logic [W-1:0]     r_rx  [Q_W];
    logic [W-1:0]     r_ry  [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_qx  [Q_W];
    logic [Q_W-1:0]   r_qy  [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];
    logic             r_vld [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int B = Q_W - 1 - j;
        logic [W-1:0]     rx_in, ry_in, dsh;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   qx_in, qy_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in, gx, gy;

        if (j == 0) begin : g_first
            assign rx_in  = W'(i_num_x);
            assign ry_in  = W'(i_num_y);
            assign den_in = i_den;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign tag_in = i_tag;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rx_in  = r_rx[j-1];
            assign ry_in  = r_ry[j-1];
            assign den_in = r_den[j-1];
            assign qx_in  = r_qx[j-1];
            assign qy_in  = r_qy[j-1];
            assign tag_in = r_tag[j-1];
            assign vld_in = r_vld[j-1];
        end

        assign dsh = W'(den_in) << B;
        assign gx  = rx_in >= dsh;
        assign gy  = ry_in >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[j]  <= gx ? rx_in - dsh : rx_in;
                r_ry[j]  <= gy ? ry_in - dsh : ry_in;
                r_den[j] <= den_in;
                r_qx[j]  <= qx_in | (Q_W'(gx) << B);
                r_qy[j]  <= qy_in | (Q_W'(gy) << B);
                r_tag[j] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_q_x   = r_qx[Q_W-1];
    assign o_q_y   = r_qy[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

// ----- design/shape_pair_collide_depenetrate.sv -----
// top level of the 2d shape pair collision and depenetration pipeline
// depends on spcd_pkg, spcd_front, spcd_sqrt, spcd_div
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------------
//  request | i_valid | o_ready | i_req_type, i_a_x/y, i_b_x/y, i_a_ext_x/y, i_b_ext_x/y
//  result  | o_valid | i_ready | o_hit, o_penetration, o_dir_x/y, o_dir_valid
//
// one beat in and one beat out per cycle while the result side is not stalled; a beat
// passes the front end, square root, depth stage, divider and output register in order
// synchronous active-low reset clears every stage valid bit; no clearing pass
// a stalled result freezes the whole pipe, so o_ready follows the output stage
module shape_pair_collide_depenetrate #(
    parameter int COORD_BITS    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic [COORD_BITS-3:0]        i_a_ext_x,
    input  logic [COORD_BITS-3:0]        i_a_ext_y,
    input  logic [COORD_BITS-3:0]        i_b_ext_x,
    input  logic [COORD_BITS-3:0]        i_b_ext_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic signed [COORD_BITS:0]   o_penetration,
    output logic signed [DIR_FRAC_BITS+1:0] o_dir_x,
    output logic signed [DIR_FRAC_BITS+1:0] o_dir_y,
    output logic                         o_dir_valid
);
    import spcd_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int DF     = DIR_FRAC_BITS;
    localparam int S_W    = 2 * CB + 1;
    localparam int L_W    = (S_W + 3) / 2;
    localparam int TAG1_W = 2 + 1 + 2 + CB + CB + (CB - 1) + (CB + 2);
    localparam int NUM_W  = CB + DF + 2;
    localparam int DEN_W  = L_W + 1;
    localparam int Q_W    = DF + 2;
    localparam int PEN_W  = CB + 1;
    localparam int TAG2_W = 2 + 1 + 2 + PEN_W + 1;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << DF;

    logic en;

    // front end
    logic                 f_vld, f_hit, f_sx, f_sy;
    t_kind                f_kind;
    logic [S_W-1:0]       f_s;
    logic [CB-1:0]        f_mdx, f_mdy;
    logic [CB-2:0]        f_rs;
    logic signed [CB+1:0] f_boxpen;

    // after the root
    logic                 sq_vld;
    logic [L_W-1:0]       sq_len;
    logic [TAG1_W-1:0]    sq_tag;
    logic [1:0]           q_kind_bits;
    t_kind                q_kind;
    logic                 q_hit, q_sx, q_sy;
    logic [CB-1:0]        q_mdx, q_mdy;
    logic [CB-2:0]        q_rs;
    logic signed [CB+1:0] q_boxpen;

    // depth and divider operand stage
    logic signed [CB+2:0] n_pen_raw;
    logic [PEN_W-1:0]     n_pen;
    logic                 n_dv;
    logic                 r_p_vld;
    logic [NUM_W-1:0]     r_p_numx, r_p_numy;
    logic [DEN_W-1:0]     r_p_den;
    logic [TAG2_W-1:0]    r_p_tag;

    // after the divider
    logic                 d_vld;
    logic [Q_W-1:0]       d_qx, d_qy, qx_c, qy_c;
    logic [TAG2_W-1:0]    d_tag;
    logic [1:0]           d_kind_bits;
    logic                 d_hit, d_sx, d_sy, d_dv;
    logic [PEN_W-1:0]     d_pen;

    logic                 r_out_vld;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    spcd_front #(.CB(CB)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_kind   (t_kind'(i_req_type)),
        .i_ax     (i_a_x),
        .i_ay     (i_a_y),
        .i_bx     (i_b_x),
        .i_by     (i_b_y),
        .i_eax    (i_a_ext_x),
        .i_eay    (i_a_ext_y),
        .i_ebx    (i_b_ext_x),
        .i_eby    (i_b_ext_y),
        .o_valid  (f_vld),
        .o_kind   (f_kind),
        .o_s      (f_s),
        .o_hit    (f_hit),
        .o_sx     (f_sx),
        .o_sy     (f_sy),
        .o_mdx    (f_mdx),
        .o_mdy    (f_mdy),
        .o_rs     (f_rs),
        .o_boxpen (f_boxpen)
    );

    spcd_sqrt #(.S_W(S_W), .TAG_W(TAG1_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_vld),
        .i_s     (f_s),
        .i_tag   ({f_kind, f_hit, f_sx, f_sy, f_mdx, f_mdy, f_rs, f_boxpen}),
        .o_valid (sq_vld),
        .o_len   (sq_len),
        .o_tag   (sq_tag)
    );

    assign {q_kind_bits, q_hit, q_sx, q_sy, q_mdx, q_mdy, q_rs, q_boxpen} = sq_tag;
    assign q_kind = t_kind'(q_kind_bits);

    always_comb begin
        case (q_kind)
            KIND_CC: n_pen_raw = signed'((CB+3)'(q_rs)) - signed'((CB+3)'(sq_len));
            KIND_BB: n_pen_raw = (CB+3)'(q_boxpen);
            default: n_pen_raw = '0;
        endcase
        // clip to the signed output range
        if (n_pen_raw[CB+2:CB] == {3{n_pen_raw[CB]}}) begin
            n_pen = n_pen_raw[CB:0];
        end else begin
            n_pen = {n_pen_raw[CB+2], {CB{~n_pen_raw[CB+2]}}};
        end
        // zero length means coincident centres
        n_dv = ((q_kind == KIND_CC) || (q_kind == KIND_BB)) && (sq_len != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_numx <= (NUM_W'(q_mdx) << (DF + 1)) + NUM_W'(sq_len);
            r_p_numy <= (NUM_W'(q_mdy) << (DF + 1)) + NUM_W'(sq_len);
            r_p_den  <= {sq_len, 1'b0};
            r_p_tag  <= {q_kind_bits, q_hit, q_sx, q_sy, n_pen, n_dv};
        end
    end

    spcd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(TAG2_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_vld),
        .i_num_x (r_p_numx),
        .i_num_y (r_p_numy),
        .i_den   (r_p_den),
        .i_tag   (r_p_tag),
        .o_valid (d_vld),
        .o_q_x   (d_qx),
        .o_q_y   (d_qy),
        .o_tag   (d_tag)
    );

    assign {d_kind_bits, d_hit, d_sx, d_sy, d_pen, d_dv} = d_tag;
    assign qx_c = (d_qx > Q_ONE) ? Q_ONE : d_qx;
    assign qy_c = (d_qy > Q_ONE) ? Q_ONE : d_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit         <= d_hit && (t_kind'(d_kind_bits) != KIND_NONE);
            o_penetration <= d_pen;
            o_dir_x       <= d_dv ? (d_sx ? -qx_c : qx_c) : '0;
            o_dir_y       <= d_dv ? (d_sy ? -qy_c : qy_c) : '0;
            o_dir_valid   <= d_dv;
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ----- design/spcd_checker.sv -----
// port-level checks for the shape pair collision pipeline, bound to the top level
// depends on shape_pair_collide_depenetrate
module spcd_checker #(
    parameter int COORD_BITS    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_ready,
    input logic                            o_hit,
    input logic signed [COORD_BITS:0]      o_penetration,
    input logic signed [DIR_FRAC_BITS+1:0] o_dir_x,
    input logic signed [DIR_FRAC_BITS+1:0] o_dir_y,
    input logic                            o_dir_valid
);
    localparam logic signed [DIR_FRAC_BITS+1:0] D_ONE = (DIR_FRAC_BITS+2)'(1) << DIR_FRAC_BITS;
    localparam logic signed [DIR_FRAC_BITS+1:0] D_NEG = -D_ONE;

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_penetration) &&
                                $stable(o_dir_x) && $stable(o_dir_y) && $stable(o_dir_valid))
        else $error("result beat changed while stalled");

    // a stalled output freezes the pipe, so no new request is taken
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request side ready during output stall");

    a_nodir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dir_valid |-> (o_dir_x == '0) && (o_dir_y == '0))
        else $error("direction nonzero without dir_valid");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dir_valid |-> (o_dir_x <= D_ONE) && (o_dir_x >= D_NEG) &&
                                   (o_dir_y <= D_ONE) && (o_dir_y >= D_NEG))
        else $error("direction component beyond unit length");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind shape_pair_collide_depenetrate spcd_checker #(
    .COORD_BITS    (COORD_BITS),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
) u_spcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ready       (o_ready),
    .o_hit         (o_hit),
    .o_penetration (o_penetration),
    .o_dir_x       (o_dir_x),
    .o_dir_y       (o_dir_y),
    .o_dir_valid   (o_dir_valid)
);

// ----- tb/sv/tb_shape_pair_collide_depenetrate.sv -----
// testbench for shape_pair_collide_depenetrate: directed and random shape pairs
// depends on spcd_pkg and the block rtl; a scoreboard class predicts each result
`timescale 1ns / 1ps

import spcd_pkg::*;

typedef struct packed {
    logic               hit;
    logic signed [24:0] pen;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               dv;
} t_contact;

class contact_board;
    t_contact pending[$];
    int       n_err;
    int       n_seen;
    int       n_hit;

    function automatic logic [127:0] isqrt_round(logic [127:0] s);
        logic [127:0] n, r, t;
        n = s << 2;
        r = 0;
        for (int b = 34; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (n >= t * t) r = t;
        end
        return (r + 1) >> 1;
    endfunction

    function automatic logic signed [15:0] unit_comp(longint d, longint len);
        longint m, q;
        m = d < 0 ? -d : d;
        q = ((m << 15) + len) / (2 * len);
        if (q > (64'sd1 << 14)) q = 64'sd1 << 14;
        return d < 0 ? 16'(-q) : 16'(q);
    endfunction

    function void note_pair(t_kind kind, longint ax, longint ay, longint bx, longint by,
                            longint eax, longint eay, longint ebx, longint eby);
        t_contact     c;
        longint       dx, dy, rs, ox, oy, cx, cy, pen, len;
        logic [127:0] s, q;
        bit           with_dir;
        c = '0;
        dx = bx - ax;
        dy = by - ay;
        s = 128'(dx * dx) + 128'(dy * dy);
        with_dir = 0;
        pen = 0;
        len = longint'(isqrt_round(s));
        case (kind)
            KIND_CC: begin
                rs = eax + ebx;
                c.hit = s < 128'(rs * rs);
                pen = rs - len;
                with_dir = 1;
            end
            KIND_BB: begin
                ox = (eax + ebx) - (dx < 0 ? -dx : dx);
                oy = (eay + eby) - (dy < 0 ? -dy : dy);
                c.hit = (ax - eax < bx + ebx) && (ax + eax > bx - ebx) &&
                        (ay - eay < by + eby) && (ay + eay > by - eby);
                pen = ox < oy ? ox : oy;
                with_dir = 1;
            end
            KIND_CB: begin
                cx = ax;
                cy = ay;
                if (cx < bx - ebx) cx = bx - ebx;
                if (cx > bx + ebx) cx = bx + ebx;
                if (cy < by - eby) cy = by - eby;
                if (cy > by + eby) cy = by + eby;
                q = 128'((ax - cx) * (ax - cx)) + 128'((ay - cy) * (ay - cy));
                c.hit = q < 128'(eax * eax);
            end
            default: ;
        endcase
        if (with_dir) begin
            if (pen > 16777215) pen = 16777215;
            if (pen < -16777216) pen = -16777216;
            c.pen = 25'(pen);
            if (s != 0) begin
                c.dx = unit_comp(dx, len);
                c.dy = unit_comp(dy, len);
                c.dv = 1;
            end
        end
        pending.push_back(c);
    endfunction

    function void check_contact(t_contact got);
        t_contact e;
        n_seen++;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            n_err++;
            return;
        end
        e = pending.pop_front();
        if (got.hit) n_hit++;
        if (got.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, got.hit); n_err++;
        end
        if (got.pen !== e.pen) begin
            $error("penetration exp %0d got %0d", e.pen, got.pen); n_err++;
        end
        if (got.dx !== e.dx) begin
            $error("dir_x exp %0d got %0d", e.dx, got.dx); n_err++;
        end
        if (got.dy !== e.dy) begin
            $error("dir_y exp %0d got %0d", e.dy, got.dy); n_err++;
        end
        if (got.dv !== e.dv) begin
            $error("dir_valid exp %0d got %0d", e.dv, got.dv); n_err++;
        end
    endfunction
endclass

module tb_shape_pair_collide_depenetrate;
    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [1:0]         i_req_type = 0;
    logic signed [23:0] i_a_x = 0, i_a_y = 0, i_b_x = 0, i_b_y = 0;
    logic [21:0]        i_a_ext_x = 0, i_a_ext_y = 0, i_b_ext_x = 0, i_b_ext_y = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic               o_hit;
    logic signed [24:0] o_penetration;
    logic signed [15:0] o_dir_x, o_dir_y;
    logic               o_dir_valid;

    contact_board board = new();
    bit               quiet = 0;
    bit               hold_rx = 0;
    int               n_sent = 0;

    always #5 i_clk = ~i_clk;

    shape_pair_collide_depenetrate i_dut (.*);

    task automatic send_pair(logic [1:0] k, logic signed [23:0] ax, ay, bx, by,
                             logic [21:0] eax, eay, ebx, eby);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= k;
        i_a_x <= ax; i_a_y <= ay; i_b_x <= bx; i_b_y <= by;
        i_a_ext_x <= eax; i_a_ext_y <= eay; i_b_ext_x <= ebx; i_b_ext_y <= eby;
        // the beat goes in at the first edge that sees ready high
        @(posedge i_clk iff o_ready);
        board.note_pair(t_kind'(k), ax, ay, bx, by, eax, eay, ebx, eby);
        n_sent++;
    endtask

    function automatic logic signed [23:0] near_coord(logic signed [23:0] c);
        return c + 24'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    // result side: random stall bursts, one long hold-off, none near the end
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_contact({o_hit, o_penetration, o_dir_x, o_dir_y, o_dir_valid});
    end

    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rx) begin
                i_ready <= 0;
                repeat (150) @(posedge i_clk);
                hold_rx = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 3);
                i_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [1:0]         k;
        logic signed [23:0] ax, ay, bx, by;
        logic [21:0]        e0, e1, e2, e3;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // extremes, coincident centres, touching edges, unused ext_y, unknown kind
        send_pair(KIND_CC, 0, 0, 0, 0, 100, 22'h3fffff, 100, 0);
        send_pair(KIND_CC, 0, 0, 300, 400, 250, 0, 250, 0);
        send_pair(KIND_CC, 0, 0, 300, 400, 250, 0, 251, 0);
        send_pair(KIND_CC, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
                  22'h3fffff, 0, 22'h3fffff, 0);
        send_pair(KIND_CC, 24'sd8388607, 0, -24'sd8388608, 0, 22'h3fffff, 0, 22'h3fffff, 0);
        send_pair(KIND_CC, 5, 5, 5, 5, 0, 0, 0, 0);
        send_pair(KIND_BB, 0, 0, 0, 0, 10, 20, 10, 20);
        send_pair(KIND_BB, 0, 0, 20, 0, 10, 10, 10, 10);
        send_pair(KIND_BB, 0, 0, 19, 3, 10, 10, 10, 10);
        send_pair(KIND_BB, -24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608,
                  22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff);
        send_pair(KIND_BB, 0, 0, 1, 1, 22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff);
        send_pair(KIND_CB, 0, 0, 0, 0, 5, 99, 10, 10);
        send_pair(KIND_CB, 0, 0, 20, 0, 10, 0, 10, 10);
        send_pair(KIND_CB, 0, 0, 15, 15, 8, 0, 10, 10);
        send_pair(KIND_CB, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
                  22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff);
        send_pair(KIND_NONE, 0, 0, 0, 0, 100, 100, 100, 100);
        send_pair(KIND_NONE, -24'sd8388608, 24'sd8388607, 3, 4,
                  22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff);
        for (int i = 0; i < 450; i++) begin
            if (i == 120) hold_rx = 1;
            if (i == 400) quiet = 1;
            k = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
            ax = 24'($urandom);
            ay = 24'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                // full-range noise
                bx = 24'($urandom); by = 24'($urandom);
                e0 = 22'($urandom); e1 = 22'($urandom);
                e2 = 22'($urandom); e3 = 22'($urandom);
            end else begin
                // nearby shapes so hits and misses both happen
                ax = ax >>> 2; ay = ay >>> 2;
                bx = near_coord(ax); by = near_coord(ay);
                if ($urandom_range(0, 9) == 0) begin bx = ax; by = ay; end
                e0 = 22'($urandom_range(0, 4095)); e1 = 22'($urandom_range(0, 4095));
                e2 = 22'($urandom_range(0, 4095)); e3 = 22'($urandom_range(0, 4095));
            end
            send_pair(k, ax, ay, bx, by, e0, e1, e2, e3);
        end
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d shape pairs of all kinds, %0d results checked, %0d hits",
                 n_sent, board.n_seen, board.n_hit);
        if (board.n_err == 0 && board.pending.size() == 0)
            $display("shape_pair_collide_depenetrate verification clean");
        else
            $display("shape_pair_collide_depenetrate verification failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("shape_pair_collide_depenetrate verification failed");
        $finish;
    end
endmodule
